// ===== design/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Rounded box distance package
// Shared widths, register indexes and transaction types for the rounded
// rectangle signed distance pipeline.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 4;
    localparam int DIST_W     = 19;

    // Register indexes on the configuration port.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_RADIUS = 3'd4;

    // Derived datapath widths.
    localparam int HR_W   = COORD_BITS + 1;          // half extent minus radius, signed
    localparam int EXC_W  = COORD_BITS + 2;          // axis excess, signed
    localparam int POS_W  = COORD_BITS + 1;          // positive part of the excess
    localparam int SQ_W   = 2 * POS_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int RAD_W  = SUM_W + 2 * FRAC_BITS;   // scaled sum of squares
    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int RAD_PAD_W = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int SIDE_W = COORD_BITS + FRAC_BITS + 2;
    localparam int EXT_W  = ((ROOT_W + 1 > SIDE_W) ? ROOT_W + 1 : SIDE_W) + 1;
    localparam int SAT_W  = (EXT_W > DIST_W) ? EXT_W : DIST_W;

    // Four front stages, one stage per root bit, then the output register.
    localparam int LATENCY = 5 + ROOT_W;

    typedef struct packed {
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
    } t_point;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic                     inside_res;
    } t_result;

    // One slot of the square root pipeline.
    typedef struct packed {
        logic                     valid;
        logic [RAD_PAD_W-1:0]     rad;
        logic [REM_W-1:0]         rem;
        logic [ROOT_W-1:0]        root;
        logic signed [SIDE_W-1:0] side;
    } t_sq_slot;

endpackage

// ===== design/rbd_front.sv =====
// ----------------------------------------------------------------------------
// Rounded box distance front end
// Four register stages: axis distances, axis excess, squares and the
// inner term, then the scaled sum that feeds the square root pipeline.
// ----------------------------------------------------------------------------
module rbd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  rbd_pkg::t_point               i_pt,
    input  logic [rbd_pkg::COORD_BITS-1:0] i_center_x,
    input  logic [rbd_pkg::COORD_BITS-1:0] i_center_y,
    input  logic [rbd_pkg::COORD_BITS-1:0] i_half_width,
    input  logic [rbd_pkg::COORD_BITS-1:0] i_half_height,
    input  logic [rbd_pkg::COORD_BITS-1:0] i_corner_radius,
    output rbd_pkg::t_sq_slot             o_slot
);
    import rbd_pkg::*;

    // Stage 1
    logic                         r_v1;
    logic [COORD_BITS-1:0]        r_absx, r_absy, r_rad1;
    logic signed [HR_W-1:0]       r_hrx, r_hry;
    // Stage 2
    logic                         r_v2;
    logic signed [EXC_W-1:0]      r_dx, r_dy;
    logic [COORD_BITS-1:0]        r_rad2;
    // Stage 3
    logic                         r_v3;
    logic [SQ_W-1:0]              r_sqx, r_sqy;
    logic signed [SIDE_W-1:0]     r_side3;
    // Stage 4
    logic                         r_v4;
    logic [RAD_PAD_W-1:0]         r_rad4;
    logic signed [SIDE_W-1:0]     r_side4;

    logic [COORD_BITS-1:0]        n_absx, n_absy;
    logic signed [HR_W-1:0]       n_hrx, n_hry;
    logic signed [EXC_W-1:0]      n_dx, n_dy, n_m;
    logic [POS_W-1:0]             n_posx, n_posy;
    logic signed [SIDE_W-1:0]     n_inner, n_side;
    logic [SUM_W-1:0]             n_sum;

    always_comb begin
        n_absx = (i_center_x >= i_pt.point_x) ? i_center_x - i_pt.point_x
                                              : i_pt.point_x - i_center_x;
        n_absy = (i_center_y >= i_pt.point_y) ? i_center_y - i_pt.point_y
                                              : i_pt.point_y - i_center_y;
        n_hrx = $signed({1'b0, i_half_width})  - $signed({1'b0, i_corner_radius});
        n_hry = $signed({1'b0, i_half_height}) - $signed({1'b0, i_corner_radius});
    end

    always_comb begin
        n_dx = $signed({2'b00, r_absx}) - EXC_W'(r_hrx);
        n_dy = $signed({2'b00, r_absy}) - EXC_W'(r_hry);
    end

    always_comb begin
        n_posx = (r_dx > 0) ? r_dx[POS_W-1:0] : '0;
        n_posy = (r_dy > 0) ? r_dy[POS_W-1:0] : '0;
        n_m    = (r_dx > r_dy) ? r_dx : r_dy;
        // Only a point inside both straight parts gets the inner term.
        n_inner = (n_m < 0) ? (SIDE_W'(n_m) <<< FRAC_BITS) : '0;
        n_side  = n_inner - ($signed({2'b00, r_rad2, FRAC_BITS'(0)}));
    end

    always_comb begin
        n_sum = SUM_W'(r_sqx) + SUM_W'(r_sqy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_absx  <= n_absx;
        r_absy  <= n_absy;
        r_hrx   <= n_hrx;
        r_hry   <= n_hry;
        r_rad1  <= i_corner_radius;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_rad2  <= r_rad1;
        r_sqx   <= n_posx * n_posx;
        r_sqy   <= n_posy * n_posy;
        r_side3 <= n_side;
        r_rad4  <= RAD_PAD_W'({n_sum, (2 * FRAC_BITS)'(0)});
        r_side4 <= r_side3;
    end

    always_comb begin
        o_slot.valid = r_v4;
        o_slot.rad   = r_rad4;
        o_slot.rem   = '0;
        o_slot.root  = '0;
        o_slot.side  = r_side4;
    end

endmodule

// ===== design/rbd_sqrt_step.sv =====
// ----------------------------------------------------------------------------
// Rounded box distance root step
// One registered step of the restoring square root: brings down two
// radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module rbd_sqrt_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rbd_pkg::t_sq_slot i_slot,
    output rbd_pkg::t_sq_slot o_slot
);
    import rbd_pkg::*;

    logic                 r_valid;
    t_sq_slot             r_slot;
    logic [REM_W-1:0]     n_cat, n_trial;
    logic                 n_take;
    t_sq_slot             n_slot;

    always_comb begin
        n_cat   = {i_slot.rem[REM_W-3:0], i_slot.rad[RAD_PAD_W-1 -: 2]};
        n_trial = REM_W'({i_slot.root, 2'b01});
        n_take  = (n_cat >= n_trial);
        n_slot        = i_slot;
        n_slot.rad    = {i_slot.rad[RAD_PAD_W-3:0], 2'b00};
        n_slot.rem    = n_take ? n_cat - n_trial : n_cat;
        n_slot.root   = {i_slot.root[ROOT_W-2:0], n_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    always_comb begin
        o_slot       = r_slot;
        o_slot.valid = r_valid;
    end

endmodule

// ===== design/rbd_sqrt.sv =====
// ----------------------------------------------------------------------------
// Rounded box distance square root pipeline
// A chain of root steps, one per result bit, giving the floor square
// root of the scaled sum with the inner term carried alongside.
// ----------------------------------------------------------------------------
module rbd_sqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rbd_pkg::t_sq_slot i_slot,
    output rbd_pkg::t_sq_slot o_slot
);
    import rbd_pkg::*;

    t_sq_slot chain [ROOT_W+1];

    assign chain[0] = i_slot;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_step
        rbd_sqrt_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_slot  (chain[g]),
            .o_slot  (chain[g+1])
        );
    end

    assign o_slot = chain[ROOT_W];

endmodule

// ===== design/rounded_box_distance_unit.sv =====
// ----------------------------------------------------------------------------
// Rounded box distance unit
// Signed distance from a point to a configured rounded rectangle, in
// 1/16 pixel, with a flag for points on or inside the shape.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// point     in         i_start, o_busy           i_pt (t_point)
// result    out        o_done strobe             o_res (t_result)
// config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A point is taken in every cycle; o_busy stays low.
// Each result passes through four front stages, one stage per root bit
// (18), and the output register after its point is taken.
// Synchronous reset clears the configuration registers and all valid bits in flight.
// The receiver cannot stall, so the pipeline always advances.
// ----------------------------------------------------------------------------
module rounded_box_distance_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  rbd_pkg::t_point                i_pt,
    output logic                           o_done,
    output rbd_pkg::t_result               o_res,
    input  logic                           i_cfg_we,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rbd_pkg::COORD_BITS-1:0] i_cfg_data
);
    import rbd_pkg::*;

    logic [COORD_BITS-1:0] r_center_x, r_center_y;
    logic [COORD_BITS-1:0] r_half_width, r_half_height, r_corner_radius;
    logic                  r_done;
    t_result               r_res;

    t_sq_slot                front_slot, root_slot;
    logic signed [SAT_W-1:0] n_sum, n_sat;

    localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'((2 ** (DIST_W - 1)) - 1);
    localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_MAX - SAT_W'(1);

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x      <= '0;
            r_center_y      <= '0;
            r_half_width    <= '0;
            r_half_height   <= '0;
            r_corner_radius <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CENTER_X:      r_center_x      <= i_cfg_data;
                REG_CENTER_Y:      r_center_y      <= i_cfg_data;
                REG_HALF_WIDTH:    r_half_width    <= i_cfg_data;
                REG_HALF_HEIGHT:   r_half_height   <= i_cfg_data;
                REG_CORNER_RADIUS: r_corner_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rbd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_start && !o_busy),
        .i_pt            (i_pt),
        .i_center_x      (r_center_x),
        .i_center_y      (r_center_y),
        .i_half_width    (r_half_width),
        .i_half_height   (r_half_height),
        .i_corner_radius (r_corner_radius),
        .o_slot          (front_slot)
    );

    rbd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slot  (front_slot),
        .o_slot  (root_slot)
    );

    always_comb begin
        n_sum = $signed(SAT_W'({1'b0, root_slot.root})) + SAT_W'(root_slot.side);
        if (n_sum > SAT_MAX) begin
            n_sat = SAT_MAX;
        end else if (n_sum < SAT_MIN) begin
            n_sat = SAT_MIN;
        end else begin
            n_sat = n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= root_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.distance   <= n_sat[DIST_W-1:0];
        r_res.inside_res <= (n_sat <= 0);
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== design/rbd_checker.sv =====
// ----------------------------------------------------------------------------
// Rounded box distance checker
// Port-level assertions on result timing and the inside flag, bound to
// the top level.
// ----------------------------------------------------------------------------
module rbd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_start,
    input logic                           o_busy,
    input rbd_pkg::t_point                i_pt,
    input logic                           o_done,
    input rbd_pkg::t_result               o_res,
    input logic                           i_cfg_we,
    input logic [rbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [rbd_pkg::COORD_BITS-1:0] i_cfg_data
);
    import rbd_pkg::*;

    // Every accepted transaction yields exactly one result after the fixed latency.
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_done)
        else $error("result missing after accepted transaction");

    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, LATENCY))
        else $error("result without matching transaction");

    // The flag must agree with the sign of the reported distance.
    a_inside_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.inside_res == ($signed(o_res.distance) <= 0)))
        else $error("inside flag disagrees with distance");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

endmodule

bind rounded_box_distance_unit rbd_checker u_rbd_checker (.*);
